### rtl/crc16m_pkg.sv
// Shared types, constants and the CRC byte update for the CRC-16/Modbus block.
`default_nettype none
package crc16m_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // queue between the front and the back end
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one classified byte on its way to the back end
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] crc;
    logic        last;    // last byte of the frame
    logic        append;  // two CRC bytes follow this echo
    logic        good;    // check mode, residue zero
  } crc16m_entry_t;

  // reflected CRC-16, LSB first, one byte in eight steps
  function automatic logic [15:0] crc16m_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/crc16m_front.sv
// Front end: takes input bytes, keeps the running CRC, classifies each byte.
`default_nettype none
module crc16m_front
  import crc16m_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mode_i,
  input  wire logic          s_valid_i,
  input  wire logic [7:0]    s_data_i,
  input  wire logic          s_last_i,
  output logic               s_ready_o,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output crc16m_entry_t      q_entry_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && s_ready_o;
  assign crc_next  = crc16m_byte(crc_q, s_data_i);

  always_comb begin
    q_entry_o.data   = s_data_i;
    q_entry_o.crc    = crc_next;
    q_entry_o.last   = s_last_i;
    q_entry_o.append = s_last_i && !mode_i;
    q_entry_o.good   = s_last_i && mode_i && (crc_next == 16'h0000);
  end

  always_comb begin
    crc_d = crc_q;
    if (q_push_o) begin
      crc_d = s_last_i ? CrcInit : crc_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule
`default_nettype wire

### rtl/crc16m_fifo.sv
// Small register queue between the front and the back end.
`default_nettype none
module crc16m_fifo
  import crc16m_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire crc16m_entry_t push_entry_i,
  input  wire logic          pop_i,
  output crc16m_entry_t      head_o,
  output logic               empty_o,
  output logic               full_o,
  output logic [QCntW-1:0]   count_o
);

  crc16m_entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]         cnt_q, cnt_d;
  logic                     do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

### rtl/crc16m_back.sv
// Back end: drains the queue into the output register, appends CRC bytes.
`default_nettype none
module crc16m_back
  import crc16m_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire crc16m_entry_t q_head_i,
  input  wire logic          q_empty_i,
  output logic               q_pop_o,
  output logic               m_valid_o,
  input  wire logic          m_ready_i,
  output logic [7:0]         m_byte_o,
  output logic [15:0]        m_crc_o,
  output logic               m_last_o,
  output logic               m_good_o
);

  typedef enum logic [2:0] {
    PhEcho  = 3'b001,
    PhCrcLo = 3'b010,
    PhCrcHi = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic [15:0] crc_q, crc_d;
  logic        last_q, last_d;
  logic        good_q, good_d;
  logic        load;

  // output register free now or being taken this cycle
  assign load    = !valid_q || m_ready_i;
  assign q_pop_o = load && (phase_q == PhEcho) && !q_empty_i;

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    crc_d   = crc_q;
    last_d  = last_q;
    good_d  = good_q;
    if (load) begin
      unique case (phase_q)
        PhEcho: begin
          valid_d = !q_empty_i;
          if (!q_empty_i) begin
            byte_d = q_head_i.data;
            crc_d  = q_head_i.crc;
            last_d = q_head_i.last && !q_head_i.append;
            good_d = q_head_i.good;
            if (q_head_i.append) begin
              phase_d = PhCrcLo;
            end
          end
        end
        PhCrcLo: begin
          valid_d = 1'b1;
          byte_d  = crc_q[7:0];
          last_d  = 1'b0;
          good_d  = 1'b0;
          phase_d = PhCrcHi;
        end
        PhCrcHi: begin
          valid_d = 1'b1;
          byte_d  = crc_q[15:8];
          last_d  = 1'b1;
          good_d  = 1'b0;
          phase_d = PhEcho;
        end
        default: begin
          valid_d = 1'b0;
          phase_d = PhEcho;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhEcho;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    crc_q  <= crc_d;
    last_q <= last_d;
    good_q <= good_d;
  end

  assign m_valid_o = valid_q;
  assign m_byte_o  = byte_q;
  assign m_crc_o   = crc_q;
  assign m_last_o  = last_q;
  assign m_good_o  = good_q;

endmodule
`default_nettype wire

### rtl/crc16_modbus_append_check.sv
// Top level of the CRC-16/Modbus append/check stream block.
// Bytes enter one per cycle while the queue has room and leave one per cycle
// while the output is ready; each byte's CRC update (reflected poly 0xA001,
// init 0xFFFF, no final xor) is done in the cycle it is accepted, and the
// result passes through the queue and the output register. mode = 0 appends
// the CRC low then high byte after the last byte, so that byte yields three
// output bytes; the four-entry queue absorbs that, and input stalls only when
// the queue is full. mode = 1 expects the frame to end with its CRC and flags
// crc_good (tuser) on the last byte when the residue is zero. The CRC restarts
// after every frame. Change mode only while the block is idle.
`default_nettype none
module crc16_modbus_append_check
  import crc16m_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,      // mode: 0 append, 1 check
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // last_flag
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [7:0] out_byte, [23:8] crc_value
  output logic             m_axis_tlast_o,   // out_last
  output logic             m_axis_tuser_o    // crc_good
);

  logic             mode_q, mode_d;
  logic             q_push, q_pop, q_empty, q_full;
  logic [QCntW-1:0] q_count;
  crc16m_entry_t    q_in, q_head;
  logic [7:0]       out_byte;
  logic [15:0]      out_crc;

  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  crc16m_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .s_valid_i (s_axis_tvalid_i),
    .s_data_i  (s_axis_tdata_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  crc16m_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .empty_o      (q_empty),
    .full_o       (q_full),
    .count_o      (q_count)
  );

  crc16m_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_head_i  (q_head),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_byte_o  (out_byte),
    .m_crc_o   (out_crc),
    .m_last_o  (m_axis_tlast_o),
    .m_good_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {out_crc, out_byte};

  // a good check result is only reported on the frame's last transaction
  a_good_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && out_crc == 16'h0000))
    else $error("crc_good without last or with nonzero residue");

  // input backpressure only when the queue is really full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (q_count == QCntW'(QDepth)))
    else $error("input stalled with room in the queue");

  // queue occupancy tracks push and pop
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire
